FILE: rtl/bsd_pkg.sv
// Shared types and constants for the bencode stream decoder.
// Depends on nothing; used by every module under rtl/ but bsd_keystore.
package bsd_pkg;

  localparam int MaxDepthDefault  = 16;
  localparam int MaxKeyLenDefault = 64;
  localparam int LengthBitsDefault = 32;

  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_INT    = 3'd0,
    KIND_STRHDR = 3'd1,
    KIND_STRBYTE = 3'd2,
    KIND_LIST   = 3'd3,
    KIND_DICT   = 3'd4,
    KIND_END    = 3'd5,
    KIND_ERR    = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    ERR_BAD_START   = 4'd0,
    ERR_NEG_ZERO    = 4'd1,
    ERR_LEAD_ZERO   = 4'd2,
    ERR_INT_BAD     = 4'd3,
    ERR_INT_OVF     = 4'd4,
    ERR_BAD_LEN     = 4'd5,
    ERR_KEY_NOT_STR = 4'd6,
    ERR_UNSORTED    = 4'd7,
    ERR_KEY_LONG    = 4'd8,
    ERR_TOO_DEEP    = 4'd9,
    ERR_TRUNCATED   = 4'd10,
    ERR_TRAILING    = 4'd11
  } err_t;

  typedef enum logic [5:0] {
    PH_VALUE      = 6'b000001,
    PH_INT_START  = 6'b000010,
    PH_INT_NEG    = 6'b000100,
    PH_INT_DIGITS = 6'b001000,
    PH_LEN        = 6'b010000,
    PH_STR        = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    CMP_EQ      = 2'd0,
    CMP_LESS    = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    kind_t              token_kind;
    logic signed [63:0] token_value;
    err_t               error_code;
    logic [4:0]         nesting_level;
    logic               message_done;
  } out_t;

endpackage

FILE: rtl/bsd_keystore.sv
// Previous-key byte store, one row per nesting level.
// Depends on nothing outside; registered read port.
module bsd_keystore #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bsd_outbuf.sv
// Output register with skid stage for token transactions.
// Depends on bsd_pkg for the token struct.
module bsd_outbuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bsd_pkg::out_t push_data,
  output logic          space,
  output logic          token_valid,
  input  logic          token_ready,
  output bsd_pkg::out_t token_item
);

  logic          out_v;
  bsd_pkg::out_t out_d;
  logic          sk_v;
  bsd_pkg::out_t sk_d;
  logic          adv;

  assign adv         = !out_v || token_ready;
  assign space       = !sk_v;
  assign token_valid = out_v;
  assign token_item  = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (adv) begin
      if (sk_v) begin
        out_v <= 1'b1;
        sk_v  <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d <= sk_v ? sk_d : push_data;
    end else if (push) begin
      sk_d <= push_data;
    end
  end

endmodule

FILE: rtl/bsd_parser.sv
// Parser state and per-byte next-state logic: phases, nesting stack, key order.
// Depends on bsd_pkg; drives the key store ports and at most one result per byte.
module bsd_parser #(
  parameter int MAX_DEPTH   = bsd_pkg::MaxDepthDefault,
  parameter int MAX_KEY_LEN = bsd_pkg::MaxKeyLenDefault,
  parameter int LENGTH_BITS = bsd_pkg::LengthBitsDefault,
  localparam int LW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1,
  localparam int KW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1,
  localparam int AW = LW + KW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          acc_en,
  input  bsd_pkg::in_t  item,
  output logic          ks_we,
  output logic [AW-1:0] ks_waddr,
  output logic [7:0]    ks_wdata,
  output logic [AW-1:0] ks_raddr,
  input  logic [7:0]    ks_rdata,
  output logic          res_valid,
  output bsd_pkg::out_t res
);

  localparam int DW  = $clog2(MAX_DEPTH + 1);
  localparam int KLW = $clog2(MAX_KEY_LEN + 1);
  localparam logic [67:0] LenLim = (68'(1) << LENGTH_BITS) - 68'(1);
  localparam logic [67:0] PosLim = 68'h7fff_ffff_ffff_ffff;
  localparam logic [67:0] NegLim = 68'h8000_0000_0000_0000;

  bsd_pkg::phase_t         phase, phase_next;
  logic [DW-1:0]           depth, depth_next;
  logic                    is_dict [MAX_DEPTH];
  logic                    is_dict_next [MAX_DEPTH];
  logic                    exp_key [MAX_DEPTH];
  logic                    exp_key_next [MAX_DEPTH];
  logic                    pend [MAX_DEPTH];
  logic                    pend_next [MAX_DEPTH];
  logic                    has_prev [MAX_DEPTH];
  logic                    has_prev_next [MAX_DEPTH];
  logic [KLW-1:0]          prev_len [MAX_DEPTH];
  logic [KLW-1:0]          prev_len_next [MAX_DEPTH];
  logic [KLW-1:0]          cur_len, cur_len_next;
  bsd_pkg::cmp_t           cmp, cmp_next;
  logic [63:0]             acc, acc_next;
  logic                    neg, neg_next;
  logic [LENGTH_BITS-1:0]  str_rem, str_rem_next;
  logic                    top_done, top_done_next;
  logic                    err, err_next;

  logic [7:0]              b;
  logic                    fin;
  logic                    is_dig;
  logic [3:0]              dg;
  logic [67:0]             acc_x10;
  logic [LW-1:0]           cur_lv;
  logic                    in_key_c;
  logic                    top_list;

  assign b        = item.data_byte;
  assign fin      = item.final_byte;
  assign is_dig   = (b >= bsd_pkg::CH_ZERO) && (b <= bsd_pkg::CH_NINE);
  assign dg       = 4'(b - bsd_pkg::CH_ZERO);
  assign acc_x10  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 68'(dg);
  assign cur_lv   = LW'(depth - DW'(1));
  assign in_key_c = (depth != '0) && is_dict[cur_lv] && exp_key[cur_lv];
  assign top_list = (depth != '0) && !is_dict[cur_lv];

  always_comb begin
    logic          tv;
    bsd_pkg::kind_t tkind;
    logic [63:0]   tval;
    logic [DW-1:0] tlvl;
    logic          fail_hit;
    bsd_pkg::err_t fcode;
    logic          sd;
    logic          vd;
    logic [DW-1:0] vd_depth;
    logic          kd;
    logic [LW-1:0] vl;
    logic [LW-1:0] ol;
    bsd_pkg::cmp_t cmp2;
    logic          is_err;

    phase_next    = phase;
    depth_next    = depth;
    is_dict_next  = is_dict;
    exp_key_next  = exp_key;
    pend_next     = pend;
    has_prev_next = has_prev;
    prev_len_next = prev_len;
    cur_len_next  = cur_len;
    cmp_next      = cmp;
    acc_next      = acc;
    neg_next      = neg;
    str_rem_next  = str_rem;
    top_done_next = top_done;
    err_next      = err;

    tv       = 1'b0;
    tkind    = bsd_pkg::KIND_INT;
    tval     = '0;
    tlvl     = depth;
    fail_hit = 1'b0;
    fcode    = bsd_pkg::ERR_BAD_START;
    sd       = 1'b0;
    vd       = 1'b0;
    vd_depth = depth;
    kd       = 1'b0;
    vl       = '0;
    ol       = LW'(depth);
    cmp2     = cmp;
    is_err   = 1'b0;

    ks_we    = 1'b0;
    ks_waddr = {cur_lv, cur_len[KW-1:0]};
    ks_wdata = b;

    if (acc_en && !err) begin
      unique case (phase)
        bsd_pkg::PH_VALUE: begin
          if (top_done) begin
            fail_hit = 1'b1;
            fcode    = bsd_pkg::ERR_TRAILING;
          end else if (in_key_c) begin
            if (b == bsd_pkg::CH_E) begin
              depth_next = depth - DW'(1);
              tv         = 1'b1;
              tkind      = bsd_pkg::KIND_END;
              tlvl       = depth - DW'(1);
              vd         = 1'b1;
              vd_depth   = depth - DW'(1);
            end else if (is_dig) begin
              acc_next   = 64'(dg);
              phase_next = bsd_pkg::PH_LEN;
            end else begin
              fail_hit = 1'b1;
              fcode    = bsd_pkg::ERR_KEY_NOT_STR;
            end
          end else if (b == bsd_pkg::CH_E && top_list) begin
            depth_next = depth - DW'(1);
            tv         = 1'b1;
            tkind      = bsd_pkg::KIND_END;
            tlvl       = depth - DW'(1);
            vd         = 1'b1;
            vd_depth   = depth - DW'(1);
          end else if (b == bsd_pkg::CH_I) begin
            phase_next = bsd_pkg::PH_INT_START;
            neg_next   = 1'b0;
            acc_next   = '0;
          end else if (is_dig) begin
            acc_next   = 64'(dg);
            phase_next = bsd_pkg::PH_LEN;
          end else if (b == bsd_pkg::CH_L || b == bsd_pkg::CH_D) begin
            if (depth >= DW'(MAX_DEPTH)) begin
              fail_hit = 1'b1;
              fcode    = bsd_pkg::ERR_TOO_DEEP;
            end else begin
              tv                = 1'b1;
              tkind             = (b == bsd_pkg::CH_D) ? bsd_pkg::KIND_DICT
                                                       : bsd_pkg::KIND_LIST;
              is_dict_next[ol]  = (b == bsd_pkg::CH_D);
              exp_key_next[ol]  = (b == bsd_pkg::CH_D);
              pend_next[ol]     = 1'b0;
              has_prev_next[ol] = 1'b0;
              depth_next        = depth + DW'(1);
            end
          end else begin
            fail_hit = 1'b1;
            fcode    = bsd_pkg::ERR_BAD_START;
          end
        end
        bsd_pkg::PH_INT_START: begin
          if (b == bsd_pkg::CH_MINUS) begin
            neg_next   = 1'b1;
            phase_next = bsd_pkg::PH_INT_NEG;
          end else if (is_dig) begin
            acc_next   = 64'(dg);
            phase_next = bsd_pkg::PH_INT_DIGITS;
          end else begin
            fail_hit = 1'b1;
            fcode    = bsd_pkg::ERR_INT_BAD;
          end
        end
        bsd_pkg::PH_INT_NEG: begin
          if (b == bsd_pkg::CH_ZERO) begin
            fail_hit = 1'b1;
            fcode    = bsd_pkg::ERR_NEG_ZERO;
          end else if (is_dig) begin
            acc_next   = 64'(dg);
            phase_next = bsd_pkg::PH_INT_DIGITS;
          end else begin
            fail_hit = 1'b1;
            fcode    = bsd_pkg::ERR_INT_BAD;
          end
        end
        bsd_pkg::PH_INT_DIGITS: begin
          if (is_dig) begin
            if (acc == '0) begin
              fail_hit = 1'b1;
              fcode    = bsd_pkg::ERR_LEAD_ZERO;
            end else if (acc_x10 > (neg ? NegLim : PosLim)) begin
              fail_hit = 1'b1;
              fcode    = bsd_pkg::ERR_INT_OVF;
            end else begin
              acc_next = acc_x10[63:0];
            end
          end else if (b == bsd_pkg::CH_E) begin
            phase_next = bsd_pkg::PH_VALUE;
            tv         = 1'b1;
            tkind      = bsd_pkg::KIND_INT;
            tval       = neg ? (64'd0 - acc) : acc;
            vd         = 1'b1;
          end else begin
            fail_hit = 1'b1;
            fcode    = bsd_pkg::ERR_INT_BAD;
          end
        end
        bsd_pkg::PH_LEN: begin
          if (is_dig) begin
            if (acc == '0 || acc_x10 > LenLim) begin
              fail_hit = 1'b1;
              fcode    = bsd_pkg::ERR_BAD_LEN;
            end else begin
              acc_next = acc_x10[63:0];
            end
          end else if (b == bsd_pkg::CH_COLON) begin
            if (in_key_c && acc > 64'(MAX_KEY_LEN)) begin
              fail_hit = 1'b1;
              fcode    = bsd_pkg::ERR_KEY_LONG;
            end else begin
              tv           = 1'b1;
              tkind        = bsd_pkg::KIND_STRHDR;
              tval         = acc;
              str_rem_next = acc[LENGTH_BITS-1:0];
              cur_len_next = '0;
              cmp_next     = bsd_pkg::CMP_EQ;
              if (acc == '0) begin
                sd = 1'b1;
              end else begin
                phase_next = bsd_pkg::PH_STR;
              end
            end
          end else begin
            fail_hit = 1'b1;
            fcode    = bsd_pkg::ERR_BAD_LEN;
          end
        end
        bsd_pkg::PH_STR: begin
          tv    = 1'b1;
          tkind = bsd_pkg::KIND_STRBYTE;
          tval  = 64'(b);
          if (in_key_c && cur_len < KLW'(MAX_KEY_LEN)) begin
            if (cmp == bsd_pkg::CMP_EQ && cur_len < prev_len[cur_lv]) begin
              if (b < ks_rdata) begin
                cmp_next = bsd_pkg::CMP_LESS;
              end else if (b > ks_rdata) begin
                cmp_next = bsd_pkg::CMP_GREATER;
              end
            end
            ks_we        = 1'b1;
            cur_len_next = cur_len + KLW'(1);
          end
          str_rem_next = str_rem - LENGTH_BITS'(1);
          if (str_rem_next == '0) begin
            sd = 1'b1;
          end
        end
        default: begin
          fail_hit = 1'b1;
          fcode    = bsd_pkg::ERR_BAD_START;
        end
      endcase

      if (sd) begin
        phase_next = bsd_pkg::PH_VALUE;
        if (in_key_c) begin
          kd = 1'b1;
        end else begin
          vd = 1'b1;
        end
      end

      if (kd) begin
        cmp2 = cmp_next;
        if (cmp2 == bsd_pkg::CMP_EQ) begin
          if (cur_len_next < prev_len[cur_lv]) begin
            cmp2 = bsd_pkg::CMP_LESS;
          end else if (cur_len_next > prev_len[cur_lv]) begin
            cmp2 = bsd_pkg::CMP_GREATER;
          end
        end
        pend_next[cur_lv]     = has_prev[cur_lv] && (cmp2 == bsd_pkg::CMP_LESS);
        prev_len_next[cur_lv] = cur_len_next;
        has_prev_next[cur_lv] = 1'b1;
        exp_key_next[cur_lv]  = 1'b0;
      end

      if (vd) begin
        if (vd_depth == '0) begin
          top_done_next = 1'b1;
        end else begin
          vl = LW'(vd_depth - DW'(1));
          if (is_dict[vl]) begin
            if (pend[vl]) begin
              fail_hit = 1'b1;
              fcode    = bsd_pkg::ERR_UNSORTED;
            end
            exp_key_next[vl] = 1'b1;
          end
        end
      end

      if (!fail_hit && fin && !top_done_next) begin
        fail_hit = 1'b1;
        fcode    = bsd_pkg::ERR_TRUNCATED;
      end

      if (fail_hit) begin
        tv       = 1'b1;
        tkind    = bsd_pkg::KIND_ERR;
        tval     = '0;
        tlvl     = depth_next;
        err_next = 1'b1;
        is_err   = 1'b1;
      end
    end

    res_valid         = tv;
    res.token_kind    = tkind;
    res.token_value   = tval;
    res.error_code    = is_err ? fcode : bsd_pkg::ERR_BAD_START;
    res.nesting_level = 5'(tlvl);
    res.message_done  = is_err || fin;

    if (acc_en && fin) begin
      phase_next    = bsd_pkg::PH_VALUE;
      depth_next    = '0;
      cur_len_next  = '0;
      cmp_next      = bsd_pkg::CMP_EQ;
      acc_next      = '0;
      neg_next      = 1'b0;
      str_rem_next  = '0;
      top_done_next = 1'b0;
      err_next      = 1'b0;
    end

    ks_raddr = {LW'(depth_next - DW'(1)), cur_len_next[KW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= bsd_pkg::PH_VALUE;
      depth    <= '0;
      cur_len  <= '0;
      cmp      <= bsd_pkg::CMP_EQ;
      acc      <= '0;
      neg      <= 1'b0;
      str_rem  <= '0;
      top_done <= 1'b0;
      err      <= 1'b0;
    end else begin
      phase    <= phase_next;
      depth    <= depth_next;
      cur_len  <= cur_len_next;
      cmp      <= cmp_next;
      acc      <= acc_next;
      neg      <= neg_next;
      str_rem  <= str_rem_next;
      top_done <= top_done_next;
      err      <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    is_dict  <= is_dict_next;
    exp_key  <= exp_key_next;
    pend     <= pend_next;
    has_prev <= has_prev_next;
    prev_len <= prev_len_next;
  end

endmodule

FILE: rtl/bencode_stream_decoder_core.sv
// Top level of the bencode stream decoder: parser, key store, token buffer.
// Depends on bsd_pkg, bsd_parser, bsd_keystore and bsd_outbuf.
//
//   channel   direction  handshake                 payload
//   byte      in         byte_valid / byte_ready   byte_item  (bsd_pkg::in_t)
//   token     out        token_valid / token_ready token_item (bsd_pkg::out_t)
//
// One byte per cycle while byte_ready is high, zero or one token per byte; each
// token is registered in the output register before it appears on the output.
// The key store is read ahead, addressed from the next parser state, so the
// byte compare needs no wait state.
// Reset clears parser control state; stack flags and the key store are
// written before they are read. A stalled token parks in a skid stage, and
// byte_ready drops only while that stage is occupied.
module bencode_stream_decoder_core #(
  parameter int MAX_DEPTH   = bsd_pkg::MaxDepthDefault,
  parameter int MAX_KEY_LEN = bsd_pkg::MaxKeyLenDefault,
  parameter int LENGTH_BITS = bsd_pkg::LengthBitsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  bsd_pkg::in_t  byte_item,
  output logic          token_valid,
  input  logic          token_ready,
  output bsd_pkg::out_t token_item
);

  localparam int LW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int KW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int AW = LW + KW;

  logic          acc_en;
  logic          ks_we;
  logic [AW-1:0] ks_waddr;
  logic [7:0]    ks_wdata;
  logic [AW-1:0] ks_raddr;
  logic [7:0]    ks_rdata;
  logic          res_valid;
  bsd_pkg::out_t res;

  assign acc_en = byte_valid && byte_ready;

  bsd_parser #(
    .MAX_DEPTH  (MAX_DEPTH),
    .MAX_KEY_LEN(MAX_KEY_LEN),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .acc_en   (acc_en),
    .item     (byte_item),
    .ks_we    (ks_we),
    .ks_waddr (ks_waddr),
    .ks_wdata (ks_wdata),
    .ks_raddr (ks_raddr),
    .ks_rdata (ks_rdata),
    .res_valid(res_valid),
    .res      (res)
  );

  bsd_keystore #(
    .AW(AW)
  ) u_keystore (
    .clk  (clk),
    .we   (ks_we),
    .waddr(ks_waddr),
    .wdata(ks_wdata),
    .raddr(ks_raddr),
    .rdata(ks_rdata)
  );

  bsd_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .space      (byte_ready),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_item (token_item)
  );

  a_res_needs_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> acc_en)
    else $error("token produced without a byte transaction");

  a_full_shows_token: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> token_valid)
    else $error("skid stage occupied while output register empty");

  a_err_ends_msg: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.token_kind == bsd_pkg::KIND_ERR |-> res.message_done)
    else $error("error token without message end");

  a_code_only_on_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.token_kind != bsd_pkg::KIND_ERR
      |-> res.error_code == bsd_pkg::ERR_BAD_START)
    else $error("error code set on a non-error token");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for bencode_stream_decoder_core: bencode messages with random
// content, noise and corruption, compared against a cycle-free decoder model.
// Depends on bsd_pkg and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          byte_valid = 1'b0;
  logic          byte_ready;
  bsd_pkg::in_t  byte_item = '0;
  logic          token_valid;
  logic          token_ready = 1'b0;
  bsd_pkg::out_t token_item;

  bencode_stream_decoder_core u_top (
    .clk(clk), .rst(rst), .byte_valid(byte_valid), .byte_ready(byte_ready),
    .byte_item(byte_item), .token_valid(token_valid), .token_ready(token_ready),
    .token_item(token_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  bsd_pkg::in_t  pend_bytes[$];
  bsd_pkg::out_t token_q[$];
  logic [7:0]    msg[$];
  int            mismatches = 0;

  // decoder model state
  bsd_pkg::phase_t ph;
  int              depth;
  bit              is_dict[16], exp_key[16], unsorted[16], has_prev[16];
  logic [7:0]      pkey[1024];
  int              plen[16];
  int              ckl;
  bsd_pkg::cmp_t   cmpr;
  logic [63:0]     acc;
  logic [63:0]     str_left;
  bit              neg, top_done, err_l;
  bit              t_valid;
  bsd_pkg::out_t   tok;

  function automatic bit is_dig(logic [7:0] b);
    return b >= bsd_pkg::CH_ZERO && b <= bsd_pkg::CH_NINE;
  endfunction

  task automatic put(bsd_pkg::kind_t k, logic [63:0] v);
    t_valid = 1'b1;
    tok.token_kind = k;
    tok.token_value = v;
    tok.error_code = bsd_pkg::ERR_BAD_START;
    tok.nesting_level = depth[4:0];
  endtask

  task automatic fail(bsd_pkg::err_t c);
    put(bsd_pkg::KIND_ERR, 64'd0);
    tok.error_code = c;
    err_l = 1'b1;
  endtask

  function automatic bit in_key();
    return depth > 0 && is_dict[depth-1] && exp_key[depth-1];
  endfunction

  task automatic value_done();
    if (depth == 0) begin
      top_done = 1'b1;
    end else if (is_dict[depth-1]) begin
      if (unsorted[depth-1]) fail(bsd_pkg::ERR_UNSORTED);
      exp_key[depth-1] = 1'b1;
    end
  endtask

  task automatic string_done();
    bsd_pkg::cmp_t c;
    int lv;
    ph = bsd_pkg::PH_VALUE;
    if (in_key()) begin
      lv = depth - 1;
      c = cmpr;
      if (c == bsd_pkg::CMP_EQ) begin
        if (ckl < plen[lv]) c = bsd_pkg::CMP_LESS;
        else if (ckl > plen[lv]) c = bsd_pkg::CMP_GREATER;
      end
      unsorted[lv] = has_prev[lv] && c == bsd_pkg::CMP_LESS;
      plen[lv] = ckl;
      has_prev[lv] = 1'b1;
      exp_key[lv] = 1'b0;
    end else begin
      value_done();
    end
  endtask

  task automatic open_cont(bit dct);
    if (depth >= 16) begin
      fail(bsd_pkg::ERR_TOO_DEEP);
    end else begin
      put(dct ? bsd_pkg::KIND_DICT : bsd_pkg::KIND_LIST, 64'd0);
      is_dict[depth] = dct;
      exp_key[depth] = dct;
      unsorted[depth] = 1'b0;
      has_prev[depth] = 1'b0;
      depth++;
    end
  endtask

  task automatic close_cont();
    depth--;
    put(bsd_pkg::KIND_END, 64'd0);
    value_done();
  endtask

  task automatic start_len(logic [7:0] b);
    acc = 64'(b - bsd_pkg::CH_ZERO);
    ph = bsd_pkg::PH_LEN;
  endtask

  task automatic reset_parse();
    ph = bsd_pkg::PH_VALUE; depth = 0; ckl = 0; cmpr = bsd_pkg::CMP_EQ; acc = '0;
    neg = 0; str_left = '0; top_done = 0; err_l = 0;
  endtask

  task automatic decode_byte(bsd_pkg::in_t it);
    logic [7:0]  b;
    logic [63:0] dg, lim;
    int lv, idx;
    b = it.data_byte;
    dg = 64'(b - bsd_pkg::CH_ZERO);
    t_valid = 1'b0;
    tok = '0;
    if (err_l) begin
      if (it.final_byte) reset_parse();
      return;
    end
    unique case (ph)
      bsd_pkg::PH_VALUE: begin
        if (top_done) fail(bsd_pkg::ERR_TRAILING);
        else if (in_key()) begin
          if (b == bsd_pkg::CH_E) close_cont();
          else if (is_dig(b)) start_len(b);
          else fail(bsd_pkg::ERR_KEY_NOT_STR);
        end else if (b == bsd_pkg::CH_E && depth > 0 && !is_dict[depth-1]) close_cont();
        else if (b == bsd_pkg::CH_I) begin
          ph = bsd_pkg::PH_INT_START; neg = 0; acc = '0;
        end else if (is_dig(b)) start_len(b);
        else if (b == bsd_pkg::CH_L || b == bsd_pkg::CH_D) open_cont(b == bsd_pkg::CH_D);
        else fail(bsd_pkg::ERR_BAD_START);
      end
      bsd_pkg::PH_INT_START, bsd_pkg::PH_INT_NEG: begin
        if (ph == bsd_pkg::PH_INT_START && b == bsd_pkg::CH_MINUS) begin
          neg = 1; ph = bsd_pkg::PH_INT_NEG;
        end else if (ph == bsd_pkg::PH_INT_NEG && b == bsd_pkg::CH_ZERO) begin
          fail(bsd_pkg::ERR_NEG_ZERO);
        end else if (is_dig(b)) begin
          acc = dg; ph = bsd_pkg::PH_INT_DIGITS;
        end else fail(bsd_pkg::ERR_INT_BAD);
      end
      bsd_pkg::PH_INT_DIGITS: begin
        if (is_dig(b)) begin
          lim = neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
          if (acc == 0) fail(bsd_pkg::ERR_LEAD_ZERO);
          else if (acc > (lim - dg) / 10) fail(bsd_pkg::ERR_INT_OVF);
          else acc = acc * 10 + dg;
        end else if (b == bsd_pkg::CH_E) begin
          ph = bsd_pkg::PH_VALUE;
          put(bsd_pkg::KIND_INT, neg ? 64'd0 - acc : acc);
          value_done();
        end else fail(bsd_pkg::ERR_INT_BAD);
      end
      bsd_pkg::PH_LEN: begin
        if (is_dig(b)) begin
          lim = 64'hFFFFFFFF;
          if (acc == 0 || acc > (lim - dg) / 10) fail(bsd_pkg::ERR_BAD_LEN);
          else acc = acc * 10 + dg;
        end else if (b == bsd_pkg::CH_COLON) begin
          if (in_key() && acc > 64) fail(bsd_pkg::ERR_KEY_LONG);
          else begin
            put(bsd_pkg::KIND_STRHDR, acc);
            str_left = acc; ckl = 0; cmpr = bsd_pkg::CMP_EQ;
            if (str_left == 0) string_done();
            else ph = bsd_pkg::PH_STR;
          end
        end else fail(bsd_pkg::ERR_BAD_LEN);
      end
      bsd_pkg::PH_STR: begin
        put(bsd_pkg::KIND_STRBYTE, 64'(b));
        if (in_key()) begin
          lv = depth - 1;
          if (ckl < 64) begin
            idx = lv * 64 + ckl;
            if (cmpr == bsd_pkg::CMP_EQ && ckl < plen[lv]) begin
              if (b < pkey[idx]) cmpr = bsd_pkg::CMP_LESS;
              else if (b > pkey[idx]) cmpr = bsd_pkg::CMP_GREATER;
            end
            pkey[idx] = b;
            ckl++;
          end
        end
        str_left--;
        if (str_left == 0) string_done();
      end
      default: fail(bsd_pkg::ERR_BAD_START);
    endcase
    if (!err_l && it.final_byte && !top_done) fail(bsd_pkg::ERR_TRUNCATED);
    if (t_valid) begin
      tok.message_done = (tok.token_kind == bsd_pkg::KIND_ERR) || it.final_byte;
      token_q.push_back(tok);
    end
    if (it.final_byte) reset_parse();
  endtask

  // message builders
  task automatic push_txt(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic send_msg();
    bsd_pkg::in_t it;
    for (int i = 0; i < msg.size(); i++) begin
      it.data_byte = msg[i];
      it.final_byte = (i == msg.size() - 1);
      pend_bytes.push_back(it);
    end
    msg.delete();
  endtask

  task automatic send_txt(string s);
    push_txt(s);
    send_msg();
  endtask

  task automatic gen_val(input int lvl);
    int n, r, klen;
    logic [63:0] v;
    logic [7:0] letter;
    r = (lvl < 4) ? $urandom_range(0, 3) : $urandom_range(0, 1);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: v = {$urandom, $urandom};
          1: v = 64'd0 - 64'($urandom_range(0, 1000));
          default: v = $urandom_range(0, 99);
        endcase
        push_txt($sformatf("i%0de", $signed(v)));
      end
      1: begin
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        push_txt($sformatf("%0d:", n));
        for (int i = 0; i < n; i++) msg.push_back(8'($urandom_range(0, 255)));
      end
      2: begin
        msg.push_back(bsd_pkg::CH_L);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) gen_val(lvl + 1);
        msg.push_back(bsd_pkg::CH_E);
      end
      default: begin
        msg.push_back(bsd_pkg::CH_D);
        n = $urandom_range(0, 3);
        letter = 8'h61;
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) == 0) letter = 8'($urandom_range(8'h61, 8'h66));
          else letter = letter + 8'($urandom_range(0, 1));
          klen = $urandom_range(1, 3);
          push_txt($sformatf("%0d:", klen));
          for (int k = 0; k < klen; k++) msg.push_back(letter);
          gen_val(lvl + 1);
        end
        msg.push_back(bsd_pkg::CH_E);
      end
    endcase
  endtask

  // driver
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        byte_valid <= 1'b0;
      end else if (pend_bytes.size() > 0) begin
        byte_item <= pend_bytes[0];
        decode_byte(pend_bytes[0]);
        void'(pend_bytes.pop_front());
        byte_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // monitor
  int cyc = 0;
  bsd_pkg::out_t want;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      token_ready <= 1'b0;
    end else begin
      if (cyc >= 400 && cyc < 1000) token_ready <= 1'b0;
      else if (cyc[9]) token_ready <= 1'b1;
      else token_ready <= ($urandom_range(0, 3) != 0);
      if (token_valid && token_ready) begin
        if (token_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token %p", token_item);
        end else begin
          want = token_q.pop_front();
          if (token_item.token_kind !== want.token_kind ||
              token_item.token_value !== want.token_value ||
              token_item.error_code !== want.error_code ||
              token_item.nesting_level !== want.nesting_level ||
              token_item.message_done !== want.message_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", want, token_item);
          end
        end
      end
    end
  end

  initial begin
    string s;
    int r;
    reset_parse();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_txt("i0e");
    send_txt("i-0e");
    send_txt("i03e");
    send_txt("ie");
    send_txt("i-e");
    send_txt("i9223372036854775807e");
    send_txt("i-9223372036854775808e");
    send_txt("i9223372036854775808e");
    send_txt("i1x");
    send_txt("0:");
    send_txt("4:spam");
    send_txt("4294967295:");
    send_txt("4294967296:");
    send_txt("01:a");
    send_txt("3x");
    send_txt("le");
    send_txt("de");
    send_txt("d1:bi1e1:ai2ee");
    send_txt("d2:abi1e1:ai2ee");
    send_txt("d1:ai1e1:ai2e2:aai3ee");
    send_txt("di1ei2ee");
    send_txt("d1:ae");
    send_txt("e");
    send_txt("x");
    send_txt("i1ei2e");
    send_txt("l4:spam");
    s = "d64:";
    for (int i = 0; i < 64; i++) s = {s, "z"};
    send_txt({s, "i1ee"});
    s = "d65:";
    for (int i = 0; i < 65; i++) s = {s, "z"};
    send_txt({s, "i1ee"});
    s = "";
    for (int i = 0; i < 17; i++) s = {s, "l"};
    send_txt({s, "eee"});
    while (pend_bytes.size() < 1150) begin
      gen_val(0);
      r = $urandom_range(0, 9);
      if (r == 0) msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
      else if (r == 1 && msg.size() > 1) msg.delete(msg.size() - 1);
      else if (r == 2) gen_val(2);
      else if (r == 3) for (int i = 0; i < 17; i++) msg.push_front(bsd_pkg::CH_L);
      send_msg();
    end
    while (pend_bytes.size() != 0 || byte_valid || token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && token_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
